FILE: design/sdz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick deadzone scaler package
// Shared widths, register codes, mode codes and reset values.
// ----------------------------------------------------------------------------
package sdz_pkg;

  localparam int unsigned SAMPLE_W_DEF = 16;
  localparam int unsigned QUO_W        = 15;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned CFG_W        = 15;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [QUO_W-1:0] FRAC_ONE = 15'h7FFF;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_INDEP = 2'd1,
    MODE_CIRC  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_FULL = 2'd1,
    CFG_DEAD = 2'd2
  } cfg_idx_t;

  localparam logic [1:0]       MODE_RST = MODE_CIRC;
  localparam logic [CFG_W-1:0] FULL_RST = 15'd32767;
  localparam logic [CFG_W-1:0] DEAD_RST = 15'd7849;

endpackage
`default_nettype wire

FILE: design/stick_deadzone_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick deadzone scaler
// Removes a deadzone from a two-axis stick sample and rescales each axis.
// ----------------------------------------------------------------------------
// Usage:
//   A sample beat (in_raw_x, in_raw_y) is taken at each rising edge where
//   start is high and busy is low. busy is always low: the block is a fixed
//   pipeline and accepts one sample every cycle.
//   Each result beat (out_x, out_y) is shown for one cycle with out_strobe
//   high; results leave in the order the samples arrived. The path runs
//   through the square-root pipeline (one root bit a stage) followed by two
//   pairs of sixteen-stage dividers in turn (a range check, then one
//   quotient bit a stage).
//   The receiver cannot hold results off, so nothing ever stalls.
//   Registers are written through cfg_we/cfg_index/cfg_data; the user must
//   write them only while the pipeline is empty (the block does not enforce
//   it); index 3 is ignored. Synchronous reset empties the pipeline and
//   loads mode circular, full scale 32767 and deadzone 7849.
// ----------------------------------------------------------------------------
module stick_deadzone_scaler #(
  parameter int unsigned SAMPLE_WIDTH = sdz_pkg::SAMPLE_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_raw_x,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_raw_y,
  input  logic                              cfg_we,
  input  logic [sdz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdz_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_strobe,
  output logic signed [sdz_pkg::OUT_W-1:0]  out_x,
  output logic signed [sdz_pkg::OUT_W-1:0]  out_y
);
  import sdz_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned SQ_W   = 2 * SW;
  localparam int unsigned REM_W  = SW + 1;
  localparam int unsigned TRY_W  = SW + 3;
  localparam int unsigned CMP_W  = ((SW > CFG_W) ? SW : CFG_W) + 1;
  localparam int unsigned NUM_W  = SW + 17;
  localparam int unsigned DENA_W = CFG_W + 1;
  localparam int unsigned DENB_W = SW + 1;
  localparam int unsigned SB1_W  = 2 * SW + 2;
  localparam int unsigned SBA_W  = 3 * SW + 6;
  localparam int unsigned SBB_W  = 2 * QUO_W + 4;
  localparam int unsigned PRD_W  = SW + QUO_W;

  // Configuration registers
  logic [1:0]       mode_r;
  logic [CFG_W-1:0] full_r;
  logic [CFG_W-1:0] dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RST;
      full_r <= FULL_RST;
      dead_r <= DEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[1:0];
        CFG_FULL: full_r <= cfg_data;
        CFG_DEAD: dead_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic circ;
  logic [CFG_W-1:0] d_eff;
  assign circ  = (mode_r == MODE_CIRC);
  assign d_eff = (mode_r == MODE_INDEP || mode_r == MODE_CIRC) ? dead_r : '0;

  // Stage 0: magnitudes and signs
  logic [SW-1:0] rx_u, ry_u, magx, magy;
  assign rx_u = in_raw_x;
  assign ry_u = in_raw_y;
  assign magx = rx_u[SW-1] ? (~rx_u + 1'b1) : rx_u;
  assign magy = ry_u[SW-1] ? (~ry_u + 1'b1) : ry_u;

  logic          v0_r;
  logic [SW-1:0] ax0_r, ay0_r;
  logic          nx0_r, ny0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    ax0_r <= magx;
    ay0_r <= magy;
    nx0_r <= rx_u[SW-1];
    ny0_r <= ry_u[SW-1];
  end

  // Stage 1: squares
  logic             v1_r;
  logic [SQ_W-1:0]  sqx1_r, sqy1_r;
  logic [SB1_W-1:0] sb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    sqx1_r <= ax0_r * ax0_r;
    sqy1_r <= ay0_r * ay0_r;
    sb1_r  <= {ax0_r, ay0_r, nx0_r, ny0_r};
  end

  // Square root pipeline, entry 0 holds the sum of squares.
  logic             sq_v    [SW+1];
  logic [SQ_W-1:0]  sq_s    [SW+1];
  logic [REM_W-1:0] sq_rem  [SW+1];
  logic [SW-1:0]    sq_root [SW+1];
  logic [SB1_W-1:0] sq_sb   [SW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= v1_r;
    end
    sq_s[0]    <= sqx1_r + sqy1_r;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_sb[0]   <= sb1_r;
  end

  for (genvar j = 1; j <= SW; j++) begin : g_sqrt
    logic [TRY_W-1:0] rem_t, trial;
    logic             ge;

    assign rem_t = {sq_rem[j-1], sq_s[j-1][SQ_W-1 -: 2]};
    assign trial = TRY_W'({sq_root[j-1], 2'b01});
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[j] <= 1'b0;
      end else begin
        sq_v[j] <= sq_v[j-1];
      end
      sq_s[j]    <= sq_s[j-1] << 2;
      sq_rem[j]  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      sq_root[j] <= {sq_root[j-1][SW-2:0], ge};
      sq_sb[j]   <= sq_sb[j-1];
    end
  end

  // Stage A1: deadzone test and numerator/denominator of the axis rule.
  // In circular mode the x lane carries the vector length instead.
  logic [SW-1:0] s_ax, s_ay, s_r, ma_x;
  logic          s_nx, s_ny;
  assign {s_ax, s_ay, s_nx, s_ny} = sq_sb[SW];
  assign s_r  = sq_root[SW];
  assign ma_x = circ ? s_r : s_ax;

  logic             va_r;
  logic             zx_r, zy_r, sat_r;
  logic [SW-1:0]    numx_r, numy_r;
  logic [CFG_W-1:0] den_r;
  logic [SW-1:0]    axa_r, aya_r, ra_r;
  logic             nxa_r, nya_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= sq_v[SW];
    end
    zx_r   <= CMP_W'(ma_x) <= CMP_W'(d_eff);
    zy_r   <= CMP_W'(s_ay) <= CMP_W'(d_eff);
    sat_r  <= full_r <= d_eff;
    numx_r <= ma_x - SW'(d_eff);
    numy_r <= s_ay - SW'(d_eff);
    den_r  <= full_r - d_eff;
    axa_r  <= s_ax;
    aya_r  <= s_ay;
    ra_r   <= s_r;
    nxa_r  <= s_nx;
    nya_r  <= s_ny;
  end

  // Numerator 2*num*32767 + den as shifts, divisor 2*den.
  logic [NUM_W-1:0]  nax, nay;
  logic [DENA_W-1:0] dna;
  logic [SBA_W-1:0]  sba_in, sba_out;
  assign nax = (NUM_W'(numx_r) << 16) - (NUM_W'(numx_r) << 1) + NUM_W'(den_r);
  assign nay = (NUM_W'(numy_r) << 16) - (NUM_W'(numy_r) << 1) + NUM_W'(den_r);
  assign dna = {den_r, 1'b0};
  assign sba_in = {axa_r, aya_r, ra_r, nxa_r, nya_r, zx_r, zy_r, sat_r, 1'b0};

  logic             vax, vay;
  logic [QUO_W-1:0] qax, qay;
  logic [SBA_W-1:0] sba_unused;

  sdz_div #(.NUM_W(NUM_W), .DEN_W(DENA_W), .SIDE_W(SBA_W)) u_div_ax (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (va_r),
    .in_num   (nax),
    .in_den   (dna),
    .in_side  (sba_in),
    .out_valid(vax),
    .out_quo  (qax),
    .out_side (sba_out)
  );

  sdz_div #(.NUM_W(NUM_W), .DEN_W(DENA_W), .SIDE_W(SBA_W)) u_div_ay (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (va_r),
    .in_num   (nay),
    .in_den   (dna),
    .in_side  (sba_in),
    .out_valid(vay),
    .out_quo  (qay),
    .out_side (sba_unused)
  );

  logic [SW-1:0] b_ax, b_ay, b_r;
  logic          b_nx, b_ny, b_zx, b_zy, b_sat, b_pad;
  assign {b_ax, b_ay, b_r, b_nx, b_ny, b_zx, b_zy, b_sat, b_pad} = sba_out;

  // Stage B1: wanted magnitudes
  logic             vb1_r, circb1_r;
  logic [QUO_W-1:0] wx_r, wy_r;
  logic [SW-1:0]    axb1_r, ayb1_r, rb1_r;
  logic             nxb1_r, nyb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb1_r <= 1'b0;
    end else begin
      vb1_r <= vax & vay & ~b_pad;
    end
    circb1_r <= circ;
    wx_r     <= b_zx ? '0 : (b_sat ? FRAC_ONE : qax);
    wy_r     <= b_zy ? '0 : (b_sat ? FRAC_ONE : qay);
    axb1_r   <= b_ax;
    ayb1_r   <= b_ay;
    rb1_r    <= b_r;
    nxb1_r   <= b_nx;
    nyb1_r   <= b_ny;
  end

  // Stage B2: axis times wanted length for the radial rescale.
  logic             vb2_r;
  logic [PRD_W-1:0] px_r, py_r;
  logic [SW-1:0]    rb2_r;
  logic [SBB_W-1:0] sbb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb2_r <= 1'b0;
    end else begin
      vb2_r <= vb1_r;
    end
    px_r  <= axb1_r * wx_r;
    py_r  <= ayb1_r * wx_r;
    rb2_r <= rb1_r;
    sbb_r <= {nxb1_r, nyb1_r, circb1_r, (wx_r == '0), wx_r, wy_r};
  end

  logic [NUM_W-1:0]  nbx, nby;
  logic [DENB_W-1:0] dnb;
  assign nbx = (NUM_W'(px_r) << 1) + NUM_W'(rb2_r);
  assign nby = (NUM_W'(py_r) << 1) + NUM_W'(rb2_r);
  assign dnb = {rb2_r, 1'b0};

  logic             vbx, vby;
  logic [QUO_W-1:0] qbx, qby;
  logic [SBB_W-1:0] sbb_out, sbb_unused;

  sdz_div #(.NUM_W(NUM_W), .DEN_W(DENB_W), .SIDE_W(SBB_W)) u_div_bx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vb2_r),
    .in_num   (nbx),
    .in_den   (dnb),
    .in_side  (sbb_r),
    .out_valid(vbx),
    .out_quo  (qbx),
    .out_side (sbb_out)
  );

  sdz_div #(.NUM_W(NUM_W), .DEN_W(DENB_W), .SIDE_W(SBB_W)) u_div_by (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vb2_r),
    .in_num   (nby),
    .in_den   (dnb),
    .in_side  (sbb_r),
    .out_valid(vby),
    .out_quo  (qby),
    .out_side (sbb_unused)
  );

  logic             o_nx, o_ny, o_circ, o_wz;
  logic [QUO_W-1:0] o_wx, o_wy, qx, qy;
  logic [OUT_W-1:0] mx, my;
  assign {o_nx, o_ny, o_circ, o_wz, o_wx, o_wy} = sbb_out;

  // A zero wanted length forces both axes to zero in circular mode.
  assign qx = o_circ ? (o_wz ? '0 : qbx) : o_wx;
  assign qy = o_circ ? (o_wz ? '0 : qby) : o_wy;
  assign mx = {1'b0, qx};
  assign my = {1'b0, qy};

  logic             strobe_r;
  logic [OUT_W-1:0] ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vbx & vby;
    end
    ox_r <= o_nx ? (~mx + 1'b1) : mx;
    oy_r <= o_ny ? (~my + 1'b1) : my;
  end

  assign out_strobe = strobe_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;

endmodule
`default_nettype wire

FILE: design/sdz_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Fifteen-bit quotient, one quotient bit per stage, saturating to full scale.
// ----------------------------------------------------------------------------
module sdz_div #(
  parameter int unsigned NUM_W  = 33,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [NUM_W-1:0]            in_num,
  input  logic [DEN_W-1:0]            in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [sdz_pkg::QUO_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]           out_side
);
  import sdz_pkg::*;

  localparam int unsigned WW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
  localparam int unsigned NSTG = QUO_W + 1;

  logic              vld_r  [NSTG];
  logic [WW-1:0]     rem_r  [NSTG];
  logic [DEN_W-1:0]  den_r  [NSTG];
  logic [QUO_W-1:0]  quo_r  [NSTG];
  logic              sat_r  [NSTG];
  logic [SIDE_W-1:0] side_r [NSTG];

  // First stage: a quotient that cannot fit fifteen bits saturates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    rem_r[0]  <= WW'(in_num);
    den_r[0]  <= in_den;
    quo_r[0]  <= '0;
    sat_r[0]  <= WW'(in_num) >= (WW'(in_den) << QUO_W);
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_step
    localparam int unsigned SH = QUO_W - k;
    logic [WW-1:0] dsh;
    logic          ge;

    assign dsh = WW'(den_r[k-1]) << SH;
    assign ge  = rem_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      rem_r[k]  <= ge ? (rem_r[k-1] - dsh) : rem_r[k-1];
      den_r[k]  <= den_r[k-1];
      quo_r[k]  <= quo_r[k-1] | (ge ? (QUO_W'(1) << SH) : QUO_W'(0));
      sat_r[k]  <= sat_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_quo   = sat_r[NSTG-1] ? FRAC_ONE : quo_r[NSTG-1];
  assign out_side  = side_r[NSTG-1];

endmodule
`default_nettype wire

FILE: dv/sdz_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick deadzone scaler checker
// Predicts each scaled sample from the register settings seen at the
// configuration port and compares it with every strobed result beat.
// ----------------------------------------------------------------------------
module sdz_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_raw_x,
  input  logic signed [15:0] in_raw_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               out_strobe,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  output int                 fail_count,
  output int                 pending
);
  import sdz_pkg::*;

  logic [1:0]  cur_mode;
  logic [14:0] cur_full;
  logic [14:0] cur_dead;
  logic [31:0] scaled_q[$];

  assign pending = scaled_q.size();

  function automatic longint unsigned remove_dead(longint unsigned a, longint unsigned d,
                                                  longint unsigned m);
    longint unsigned q;
    if (a <= d) return 0;
    if (m <= d) return 32767;
    q = (2 * (a - d) * 32767 + (m - d)) / (2 * (m - d));
    return (q > 32767) ? 32767 : q;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s) r |= (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [15:0] apply_sign(longint unsigned mag, logic neg);
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic logic [31:0] scale_sample(logic signed [15:0] rx, logic signed [15:0] ry);
    longint unsigned ax, ay, qx, qy, r, w;
    ax = rx[15] ? longint'(-int'(rx)) : longint'(rx);
    ay = ry[15] ? longint'(-int'(ry)) : longint'(ry);
    if (cur_mode == MODE_INDEP) begin
      qx = remove_dead(ax, cur_dead, cur_full);
      qy = remove_dead(ay, cur_dead, cur_full);
    end else if (cur_mode == MODE_CIRC) begin
      r = root_floor(ax * ax + ay * ay);
      w = remove_dead(r, cur_dead, cur_full);
      if (w == 0) begin
        qx = 0;
        qy = 0;
      end else begin
        qx = (2 * ax * w + r) / (2 * r);
        qy = (2 * ay * w + r) / (2 * r);
        if (qx > 32767) qx = 32767;
        if (qy > 32767) qy = 32767;
      end
    end else begin
      qx = remove_dead(ax, 0, cur_full);
      qy = remove_dead(ay, 0, cur_full);
    end
    return {apply_sign(qx, rx[15]), apply_sign(qy, ry[15])};
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      cur_mode <= MODE_RST;
      cur_full <= FULL_RST;
      cur_dead <= DEAD_RST;
      fail_count <= 0;
      scaled_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: cur_mode <= cfg_data[1:0];
          CFG_FULL: cur_full <= cfg_data;
          CFG_DEAD: cur_dead <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) scaled_q.push_back(scale_sample(in_raw_x, in_raw_y));
      if (out_strobe) begin
        if (scaled_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat x=%0d y=%0d", out_x, out_y);
          fail_count <= fail_count + 1;
        end else begin
          want = scaled_q.pop_front();
          if (want != {out_x, out_y}) begin
            if (fail_count < 10)
              $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       $signed(want[31:16]), $signed(want[15:0]), out_x, out_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stick deadzone scaler testbench
// Drives directed and random samples under several register settings, with
// random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import sdz_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [15:0] in_raw_x = 0, in_raw_y = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_MODE;
  logic [14:0] cfg_data = 0;
  logic out_strobe;
  logic signed [15:0] out_x, out_y;
  int fail_count, pending;
  int cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  stick_deadzone_scaler dut (.*);
  sdz_checker chk (.*);

  task automatic write_reg(cfg_idx_t idx, logic [14:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Waits for every result of the current setting, then lets the pipeline drain.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_sample(logic [15:0] x, logic [15:0] y, bit gaps);
    int g;
    g = 0;
    if (gaps) g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 70) : $urandom_range(0, 2);
    if (g != 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
    start <= 1;
    in_raw_x <= x;
    in_raw_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 12000)) ^ {16{$urandom_range(0, 1) == 1}};
      default: return 16'($urandom);
    endcase
  endfunction

  logic [15:0] edge_vals[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                16'd7849, 16'd7850, -16'sd7850, 16'h0001};

  initial begin
    logic [1:0] mode_set[7] = '{MODE_CIRC, MODE_INDEP, MODE_NONE, 2'd3, MODE_CIRC, MODE_INDEP,
                                MODE_CIRC};
    logic [14:0] full_set[7] = '{15'd32767, 15'd32767, 15'd1, 15'd20000, 15'd100, 15'd0,
                                 15'd16000};
    logic [14:0] dead_set[7] = '{15'd7849, 15'd0, 15'd0, 15'd500, 15'd32766, 15'd50, 15'd15999};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    // Directed beats at reset settings: extremes, deadzone edges.
    for (int i = 0; i < 8; i++) send_sample(edge_vals[i], edge_vals[(i * 3) % 8], 0);
    for (int i = 0; i < 8; i++) send_sample(edge_vals[i], 16'h0000, 0);
    start <= 0;
    drain();
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_MODE, 15'(mode_set[p]) | (15'($urandom) & 15'h7FFC));
      write_reg(CFG_FULL, full_set[p]);
      write_reg(CFG_DEAD, dead_set[p]);
      write_reg(cfg_idx_t'(2'd3), 15'($urandom));
      for (int i = 0; i < 4; i++) send_sample(edge_vals[i], edge_vals[7 - i], 0);
      for (int i = 0; i < 215; i++) send_sample(pick_axis(), pick_axis(), 1);
      start <= 0;
      drain();
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/sdz_pkg.sv
design/sdz_div.sv
design/stick_deadzone_scaler.sv
dv/sdz_checker.sv
dv/testbench.sv
